/* sv/rhht_pkg.sv */
// ----------------------------------------------------------------------------
// rhht_pkg
// Shared codes and constants for the Robin Hood hash table.
// ----------------------------------------------------------------------------
package rhht_pkg;

  localparam int KEY_W   = 64;
  localparam int VAL_W   = 64;
  localparam int TOTAL_W = 8;

  typedef logic [1:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ACT_SET    = 2'd0;
  localparam action_t ACT_GET    = 2'd1;
  localparam action_t ACT_REMOVE = 2'd2;
  localparam action_t ACT_CLEAR  = 2'd3;

  localparam status_t STAT_DONE     = 2'd0;
  localparam status_t STAT_NOTFOUND = 2'd1;
  localparam status_t STAT_FULL     = 2'd2;

  // splitmix64 finaliser multipliers
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

endpackage

/* sv/rhht_if.sv */
// ----------------------------------------------------------------------------
// rhht_if
// Request and response channels of the Robin Hood hash table.
// ----------------------------------------------------------------------------
interface rhht_req_if;
  import rhht_pkg::*;
  logic                   valid;
  logic                   ready;
  action_t                action;
  logic [KEY_W-1:0]       key;
  logic [VAL_W-1:0]       value;
  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

interface rhht_rsp_if;
  import rhht_pkg::*;
  logic                   valid;
  logic                   ready;
  status_t                status;
  logic                   key_existed;
  logic [VAL_W-1:0]       read_value;
  logic [TOTAL_W-1:0]     entry_total;
  modport source (output valid, status, key_existed, read_value, entry_total,
                  input ready);
  modport sink   (input valid, status, key_existed, read_value, entry_total,
                  output ready);
endinterface

/* sv/rhht_hash.sv */
// ----------------------------------------------------------------------------
// rhht_hash
// Multi-cycle splitmix64 finaliser: one shared 32x32 multiplier, six steps.
// ----------------------------------------------------------------------------
module rhht_hash #(
  parameter int IW = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [rhht_pkg::KEY_W-1:0] key,
  output logic                   done,
  output logic [IW-1:0]          slot
);
  import rhht_pkg::*;

  logic [63:0] a_r, a_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [IW-1:0] slot_r, slot_nxt;

  logic [63:0] b;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] fin;
  logic [63:0] z;

  assign b    = (step_r < 3'd3) ? MIX_C1 : MIX_C2;
  assign prod = mul_a * mul_b;
  assign fin  = {acc_r[63:32] + prod[31:0], acc_r[31:0]};
  assign z    = fin ^ (fin >> 31);

  always_comb begin
    mul_a = a_r[31:0];
    mul_b = b[31:0];
    case (step_r)
      3'd1, 3'd4: mul_b = b[63:32];
      3'd2, 3'd5: mul_a = a_r[63:32];
      default: ;
    endcase
  end

  always_comb begin
    a_nxt    = a_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    slot_nxt = slot_r;
    if (start) begin
      a_nxt    = key ^ (key >> 30);
      step_nxt = 3'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      step_nxt = step_r + 3'd1;
      case (step_r)
        3'd0, 3'd3: acc_nxt = prod;
        3'd1, 3'd4: acc_nxt = fin;
        3'd2: a_nxt = fin ^ (fin >> 27);
        default: begin
          slot_nxt = z[IW-1:0];
          done_nxt = 1'b1;
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    a_r    <= a_nxt;
    acc_r  <= acc_nxt;
    slot_r <= slot_nxt;
  end

  assign done = done_r;
  assign slot = slot_r;

endmodule

/* sv/robin_hood_hash_table.sv */
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// Open-addressed key/value table, linear probing, Robin Hood displacement,
// backward-shift removal.
// ----------------------------------------------------------------------------
// One request is handled at a time. A set, get or remove hashes the key,
// reads its home slot, then probes, displaces or shifts one slot at a time
// (the slot memory has one read port and one write port and reads one slot
// a cycle), and posts the response, which can wait on out_rsp.ready; the
// next request can be taken once the response is posted. A clear writes
// every slot empty in turn and then posts its response. After reset the
// occupancy is cleared by a pass over every slot before the first request
// is taken. A set on a new key is refused with status full once three
// quarters of the slots are in use. SLOT_COUNT must be a power of two;
// entry_total carries the low eight bits of the entry count.
module robin_hood_hash_table #(
  parameter int SLOT_COUNT = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  rhht_req_if.sink      in_req,
  rhht_rsp_if.source    out_rsp
);
  import rhht_pkg::*;

  localparam int IW    = $clog2(SLOT_COUNT);
  localparam int LIMIT = SLOT_COUNT - SLOT_COUNT / 4;
  localparam int CW    = (IW > TOTAL_W) ? IW : TOTAL_W;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  typedef struct packed {
    logic             occ;
    logic [IW-1:0]    pdist;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } ent_t;

  ent_t mem [SLOT_COUNT];
  ent_t rd_q;
  logic we, re;
  logic [IW-1:0] wa, ra;
  ent_t wd;

  logic [2:0]       state_r, state_nxt;
  action_t          act_r, act_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [IW-1:0]    pos_r, pos_nxt;
  logic [IW-1:0]    dist_r, dist_nxt;
  ent_t             cry_r, cry_nxt;
  logic [IW-1:0]    clr_idx_r, clr_idx_nxt;
  logic             clr_rsp_r, clr_rsp_nxt;
  logic [IW-1:0]    cnt_r, cnt_nxt;
  status_t          res_status_r, res_status_nxt;
  logic             res_exist_r, res_exist_nxt;
  logic [VAL_W-1:0] res_val_r, res_val_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_exist_r, out_exist_nxt;
  logic [VAL_W-1:0] out_val_r, out_val_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;

  logic          in_acc;
  logic          h_done;
  logic [IW-1:0] h_slot;
  logic [IW-1:0] p1, p2;
  logic [CW-1:0] cnt_ext;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign p1           = pos_r + IW'(1);
  assign p2           = pos_r + IW'(2);
  assign cnt_ext      = CW'(cnt_r);

  rhht_hash #(.IW(IW)) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc && (in_req.action != ACT_CLEAR)),
    .key   (in_req.key),
    .done  (h_done),
    .slot  (h_slot)
  );

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    dist_nxt       = dist_r;
    cry_nxt        = cry_r;
    clr_idx_nxt    = clr_idx_r;
    clr_rsp_nxt    = clr_rsp_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_exist_nxt  = res_exist_r;
    res_val_nxt    = res_val_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_exist_nxt  = out_exist_r;
    out_val_nxt    = out_val_r;
    out_total_nxt  = out_total_r;
    we = 1'b0;
    wa = pos_r;
    wd = '0;
    re = 1'b0;
    ra = p1;

    unique case (state_r)
      S_CLR: begin
        we          = 1'b1;
        wa          = clr_idx_r;
        clr_idx_nxt = clr_idx_r + IW'(1);
        if (clr_idx_r == '1) begin
          state_nxt = clr_rsp_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          act_nxt        = in_req.action;
          key_nxt        = in_req.key;
          val_nxt        = in_req.value;
          res_status_nxt = STAT_DONE;
          res_exist_nxt  = 1'b0;
          res_val_nxt    = '0;
          if (in_req.action == ACT_CLEAR) begin
            clr_idx_nxt = '0;
            clr_rsp_nxt = 1'b1;
            cnt_nxt     = '0;
            state_nxt   = S_CLR;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (h_done) begin
          pos_nxt   = h_slot;
          dist_nxt  = '0;
          re        = 1'b1;
          ra        = h_slot;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!rd_q.occ || (rd_q.pdist < dist_r)) begin
          if (act_r == ACT_SET) begin
            if (cnt_r >= IW'(LIMIT)) begin
              res_status_nxt = STAT_FULL;
              state_nxt      = S_DONE;
            end else begin
              cry_nxt   = '{occ: 1'b1, pdist: dist_r, key: key_r, val: val_r};
              state_nxt = S_PLACE;
            end
          end else begin
            res_status_nxt = STAT_NOTFOUND;
            state_nxt      = S_DONE;
          end
        end else if (rd_q.key == key_r) begin
          res_exist_nxt = 1'b1;
          case (act_r)
            ACT_SET: begin
              we        = 1'b1;
              wd        = rd_q;
              wd.val    = val_r;
              state_nxt = S_DONE;
            end
            ACT_GET: begin
              res_val_nxt = rd_q.val;
              state_nxt   = S_DONE;
            end
            default: begin
              cnt_nxt   = cnt_r - IW'(1);
              re        = 1'b1;
              state_nxt = S_SHIFT;
            end
          endcase
        end else begin
          pos_nxt  = p1;
          dist_nxt = dist_r + IW'(1);
          re       = 1'b1;
        end
      end
      S_PLACE: begin
        if (!rd_q.occ) begin
          we        = 1'b1;
          wd        = cry_r;
          cnt_nxt   = cnt_r + IW'(1);
          state_nxt = S_DONE;
        end else begin
          if (rd_q.pdist < cry_r.pdist) begin
            we            = 1'b1;
            wd            = cry_r;
            cry_nxt       = rd_q;
            cry_nxt.pdist = rd_q.pdist + IW'(1);
          end else begin
            cry_nxt.pdist = cry_r.pdist + IW'(1);
          end
          pos_nxt = p1;
          re      = 1'b1;
        end
      end
      S_SHIFT: begin
        we = 1'b1;
        if (!rd_q.occ || (rd_q.pdist == '0)) begin
          state_nxt = S_DONE;
        end else begin
          wd       = rd_q;
          wd.pdist = rd_q.pdist - IW'(1);
          pos_nxt  = p1;
          re       = 1'b1;
          ra       = p2;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_exist_nxt  = res_exist_r;
          out_val_nxt    = res_val_r;
          out_total_nxt  = cnt_ext[TOTAL_W-1:0];
          clr_rsp_nxt    = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      clr_rsp_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_rsp_r   <= clr_rsp_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    dist_r       <= dist_nxt;
    cry_r        <= cry_nxt;
    res_status_r <= res_status_nxt;
    res_exist_r  <= res_exist_nxt;
    res_val_r    <= res_val_nxt;
    out_status_r <= out_status_nxt;
    out_exist_r  <= out_exist_nxt;
    out_val_r    <= out_val_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.key_existed = out_exist_r;
  assign out_rsp.read_value  = out_val_r;
  assign out_rsp.entry_total = out_total_r;

endmodule

/* sv/rhht_chk.sv */
// ----------------------------------------------------------------------------
// rhht_chk
// Port-level checks on the Robin Hood hash table response channel.
// ----------------------------------------------------------------------------
module rhht_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input rhht_pkg::status_t             out_status,
  input logic                          out_key_existed,
  input logic [rhht_pkg::VAL_W-1:0]    out_read_value
);
  import rhht_pkg::*;

  // a stalled response stays valid and its read value holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value))
    else $error("response word changed while stalled");

  a_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_value != '0) |-> out_key_existed && (out_status == STAT_DONE))
    else $error("read value without a hit");

  a_exist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_existed |-> out_status == STAT_DONE)
    else $error("hit reported with failing status");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == STAT_DONE || out_status == STAT_NOTFOUND ||
                  out_status == STAT_FULL)
    else $error("undefined status code");

endmodule

bind robin_hood_hash_table rhht_chk u_rhht_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .out_status      (out_rsp.status),
  .out_key_existed (out_rsp.key_existed),
  .out_read_value  (out_rsp.read_value)
);
